[hw/rtl/ptmu_pkg.sv]
package ptmu_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PAGE_SHIFT        = 12;
    localparam int FLAG_W            = 12;
    localparam int ROOT_W            = 4;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int BASE_W            = 52;
    localparam int FRAME_W           = PA_W - PAGE_SHIFT;
    localparam int VPN_W             = VA_W - PAGE_SHIFT;
    localparam int ENTRY_W           = PA_W;
    localparam int STATUS_W          = 3;
    localparam int LEAF_W            = 53;
    localparam int IN_TDATA_W        = 120;
    localparam int OUT_TDATA_W       = 56;

    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_NO_ROOT = 3'd1,
        STATUS_NO_L3   = 3'd2,
        STATUS_NO_L2   = 3'd3,
        STATUS_NO_L1   = 3'd4
    } ptmu_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_LEAF,
        S_DONE
    } ptmu_state_t;

    typedef struct packed {
        logic              kind;
        logic [ROOT_W-1:0] root_table;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [FLAG_W-1:0] page_flags;
    } ptmu_req_t;

    typedef struct packed {
        ptmu_status_t      status;
        logic [LEAF_W-1:0] leaf_entry;
    } ptmu_result_t;

endpackage

[hw/rtl/ptmu_ram.sv]
module ptmu_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ptmu_walk.sv]
module ptmu_walk import ptmu_pkg::*; #(
    parameter int NUM_TABLES = 16,
    localparam int TW = $clog2(NUM_TABLES),
    localparam int AW = TW + IDX_W,
    localparam int NW = $clog2(NUM_TABLES + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FRAME_W-1:0] base_frame,
    input  logic               req_valid,
    output logic               req_ready,
    input  ptmu_req_t          req,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output ptmu_result_t       res
);

    localparam int CW = (NW > ROOT_W) ? NW : ROOT_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_TABLES * ENTRIES_PER_TABLE - 1);
    localparam logic [NW-1:0] NFT_MAX  = NW'(NUM_TABLES);

    ptmu_state_t        state_reg, state_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [TW-1:0]      tbl_reg, tbl_next;
    logic               unmap_reg, unmap_next;
    logic [VPN_W-1:0]   vpn_reg, vpn_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [NW-1:0]      nft_reg, nft_next;
    logic [AW-1:0]      clr_reg, clr_next;
    ptmu_result_t       res_reg, res_next;

    logic [IDX_W-1:0]   cur_idx;
    logic [AW-1:0]      cur_addr;
    logic [FRAME_W-1:0] link_off;
    logic [FLAG_W-1:0]  flags_p;
    logic               advance;
    logic               fail;
    ptmu_status_t       lvl_status;

    always_comb begin
        case (lvl_reg)
            2'd0:    cur_idx = vpn_reg[4*IDX_W-1:3*IDX_W];
            2'd1:    cur_idx = vpn_reg[3*IDX_W-1:2*IDX_W];
            2'd2:    cur_idx = vpn_reg[2*IDX_W-1:IDX_W];
            default: cur_idx = vpn_reg[IDX_W-1:0];
        endcase
        case (lvl_reg)
            2'd0:    lvl_status = STATUS_NO_L3;
            2'd1:    lvl_status = STATUS_NO_L2;
            default: lvl_status = STATUS_NO_L1;
        endcase
    end

    assign cur_addr = {tbl_reg, cur_idx};
    assign link_off = ram_rdata[ENTRY_W-1:PAGE_SHIFT] - base_frame;
    assign flags_p  = {flags_reg[FLAG_W-1:1], 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            nft_reg   <= NW'(1);
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            nft_reg   <= nft_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg   <= lvl_next;
        tbl_reg   <= tbl_next;
        unmap_reg <= unmap_next;
        vpn_reg   <= vpn_next;
        frame_reg <= frame_next;
        flags_reg <= flags_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        tbl_next   = tbl_reg;
        unmap_next = unmap_reg;
        vpn_next   = vpn_reg;
        frame_next = frame_reg;
        flags_next = flags_reg;
        nft_next   = nft_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = cur_addr;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        advance    = 1'b0;
        fail       = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    unmap_next = (req.kind == KIND_UNMAP);
                    vpn_next   = req.virt_addr[VA_W-1:PAGE_SHIFT];
                    frame_next = req.phys_addr[PA_W-1:PAGE_SHIFT];
                    flags_next = req.page_flags;
                    tbl_next   = TW'(req.root_table);
                    lvl_next   = 2'd0;
                    if (CW'(req.root_table) < CW'(nft_reg)) begin
                        state_next = S_READ;
                    end else begin
                        res_next   = '{status: STATUS_NO_ROOT, leaf_entry: '0};
                        state_next = S_DONE;
                    end
                end
            end
            S_READ: begin
                ram_re     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (ram_rdata[0]) begin
                    if (link_off < FRAME_W'(nft_reg)) begin
                        tbl_next = link_off[TW-1:0];
                        advance  = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (!unmap_reg && (nft_reg < NFT_MAX)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {base_frame + FRAME_W'(nft_reg), flags_p};
                    tbl_next  = nft_reg[TW-1:0];
                    nft_next  = nft_reg + NW'(1);
                    advance   = 1'b1;
                end else begin
                    fail = 1'b1;
                end
                if (advance) begin
                    lvl_next = lvl_reg + 2'd1;
                    if (lvl_reg == 2'd2) begin
                        state_next = S_LEAF;
                    end else begin
                        state_next = S_READ;
                    end
                end
                if (fail) begin
                    res_next   = '{status: lvl_status, leaf_entry: '0};
                    state_next = S_DONE;
                end
            end
            S_LEAF: begin
                ram_we = 1'b1;
                if (unmap_reg) begin
                    ram_wdata = '0;
                    res_next  = '{status: STATUS_OK, leaf_entry: '0};
                end else begin
                    ram_wdata = {frame_reg, flags_p};
                    res_next  = '{status: STATUS_OK,
                                  leaf_entry: {1'b0, frame_reg, flags_p}};
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

[hw/rtl/page_table_map_unmap_unit.sv]
// Map and unmap single 4 KiB pages in a four-level page table held in an
// on-chip table store of NUM_TABLES tables of 512 entries. After reset the
// store is swept to zero, one entry a cycle, with s_tready low; cfg_we
// writes are taken during the sweep. A request that walks all levels goes
// from acceptance to a result in the output register through the accept
// cycle, a read cycle and an evaluate cycle for each of the three upper
// levels, the leaf write and the hand-off. A walk that stops at a missing
// level is correspondingly shorter; a bad root goes from the accept cycle
// straight to the hand-off. The next request is accepted while a finished
// result still waits on m_tready.
module page_table_map_unmap_unit import ptmu_pkg::*; #(
    parameter int NUM_TABLES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [BASE_W-1:0]      cfg_wdata,   // table_base
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // root_table[3:0], virt_addr[51:4], phys_addr[103:52], page_flags[115:104]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,     // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[2:0], leaf_entry[55:3]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [FRAME_W-1:0]     base_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    ptmu_req_t              req;
    ptmu_result_t           res;
    logic                   res_valid;
    logic                   res_ready;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    assign req.kind       = s_tuser;
    assign req.root_table = s_tdata[3:0];
    assign req.virt_addr  = s_tdata[51:4];
    assign req.phys_addr  = s_tdata[103:52];
    assign req.page_flags = s_tdata[115:104];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_we) begin
            base_reg <= cfg_wdata[BASE_W-1:PAGE_SHIFT];
        end
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {res.leaf_entry, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ptmu_walk #(
        .NUM_TABLES (NUM_TABLES)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .base_frame (base_reg),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    ptmu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ptmu_pkg::*;

    localparam int NUM_TABLES  = 16;
    localparam int STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int NUM_PHASES  = 5;
    localparam ptmu_status_t MISS_STATUS [3] = '{STATUS_NO_L3, STATUS_NO_L2, STATUS_NO_L1};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [BASE_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [63:0]     table_store [STORE_DEPTH];
    int unsigned     next_free_table = 1;
    logic [BASE_W-1:0] table_base_q  = '0;

    ptmu_req_t       pending_requests [$];
    ptmu_result_t    expected_results [$];
    logic [26:0]     known_prefix [$];
    ptmu_req_t       sent_req;
    ptmu_result_t    want;
    int              send_idle_pct = 33;
    int              recv_idle_pct = 33;
    int              words_seen    = 0;
    int              hold_off      = 0;
    bit              held_off      = 1'b0;
    int              mismatches    = 0;

    page_table_map_unmap_unit #(
        .NUM_TABLES (NUM_TABLES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        foreach (table_store[i]) table_store[i] = '0;
    end

    function automatic ptmu_result_t walk_table_store(ptmu_req_t r);
        ptmu_result_t res;
        logic [8:0]   idx [4];
        logic [51:0]  base_pg;
        logic [51:0]  link_off;
        logic [63:0]  ent;
        int unsigned  tbl;
        int unsigned  pos;
        int           lvl;
        bit           missed;
        res.status = STATUS_OK;
        res.leaf_entry = '0;
        idx[0] = r.virt_addr[47:39];
        idx[1] = r.virt_addr[38:30];
        idx[2] = r.virt_addr[29:21];
        idx[3] = r.virt_addr[20:12];
        base_pg = {table_base_q[51:12], 12'h000};
        tbl = 32'(r.root_table);
        missed = 1'b0;
        if (tbl >= next_free_table) begin
            res.status = STATUS_NO_ROOT;
            return res;
        end
        for (lvl = 0; lvl < 3 && !missed; lvl++) begin
            pos = tbl * ENTRIES_PER_TABLE + idx[lvl];
            ent = table_store[pos];
            if (ent[0]) begin
                link_off = {ent[51:12], 12'h000} - base_pg;
                if (link_off[51:12] >= next_free_table) begin
                    missed = 1'b1;
                end else begin
                    tbl = 32'(link_off[51:12]);
                end
            end else if (r.kind == KIND_UNMAP || next_free_table >= NUM_TABLES) begin
                missed = 1'b1;
            end else begin
                tbl = next_free_table;
                next_free_table++;
                table_store[pos] = 64'(base_pg + (52'(tbl) << PAGE_SHIFT))
                                 | 64'(r.page_flags) | 64'd1;
            end
            if (missed) res.status = MISS_STATUS[lvl];
        end
        if (!missed) begin
            pos = tbl * ENTRIES_PER_TABLE + idx[3];
            if (r.kind == KIND_UNMAP) begin
                table_store[pos] = '0;
            end else begin
                table_store[pos] = {12'h000, r.phys_addr[51:12], 12'h000}
                                 | 64'(r.page_flags) | 64'd1;
                res.leaf_entry = table_store[pos][52:0];
            end
        end
        return res;
    endfunction

    task automatic queue_word(input logic kind, input logic [3:0] root,
                              input logic [47:0] va, input logic [51:0] pa,
                              input logic [11:0] flags);
        ptmu_req_t r;
        r.kind = kind;
        r.root_table = root;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.page_flags = flags;
        pending_requests.push_back(r);
        if (kind == KIND_MAP) known_prefix.push_back(va[47:21]);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(walk_table_store(sent_req));
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sent_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'h0, sent_req.page_flags, sent_req.phys_addr,
                                 sent_req.virt_addr, sent_req.root_table};
                    s_tuser  <= sent_req.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, actual %h", $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                    end
                    if (m_tdata[55:3] !== want.leaf_entry) begin
                        mismatches++;
                        $display("%0t: leaf_entry expected %h actual %h",
                                 $time, want.leaf_entry, m_tdata[55:3]);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (!held_off && words_seen >= 400) begin
                // hold off long enough to back up the input side
                held_off = 1'b1;
                hold_off = 400;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [51:0] phase_base [NUM_PHASES];
        int          phase_words [NUM_PHASES];
        int          idle_pct [NUM_PHASES];
        ptmu_req_t   item;
        int          p;
        int          n;
        phase_base[0] = 52'hF_FFFF_FFFF_FFFF;
        phase_base[1] = 52'h0_0000_0000_1ABC;
        phase_base[2] = 52'({$urandom(), $urandom()});
        phase_base[3] = 52'h0;
        phase_base[4] = 52'hF_FFFF_FFFF_F000;
        phase_words   = '{320, 250, 80, 200, 200};
        idle_pct      = '{33, 33, 33, 0, 33};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                repeat (12) @(posedge aclk);
            end
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_base[p];
            table_base_q = phase_base[p];
            send_idle_pct = idle_pct[p];
            recv_idle_pct = idle_pct[p];
            @(posedge aclk);
            cfg_we <= 1'b0;

            if (p == 0) begin
                queue_word(KIND_MAP,   4'd1,  48'h0123_4567_89AB, 52'h1, 12'h001);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_4567_89AB, 52'h0, 12'h000);
                queue_word(KIND_MAP,   4'd0,  48'h0123_4567_89AB, 52'hF_FFFF_FFFF_FFFF, 12'h000);
                queue_word(KIND_MAP,   4'd0,  48'h0123_4567_89AB, 52'h0, 12'hFFF);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_4567_89AB, 52'h0, 12'hFFF);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_4567_89AB, 52'h0, 12'h000);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_4567_A9AB, 52'h0, 12'h000);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_0567_89AB, 52'h0, 12'h000);
                queue_word(KIND_UNMAP, 4'd0,  48'h0123_4547_89AB, 52'h0, 12'h000);
                queue_word(KIND_MAP,   4'd15, 48'hFFFF_FFFF_FFFF, 52'h5_A5A5_A5A5_A5A5, 12'h555);
                queue_word(KIND_MAP,   4'd2,  48'hFFFF_FFFF_FFFF, 52'hA_5A5A_5A5A_5A5A, 12'hAAA);
                queue_word(KIND_MAP,   4'd0,  48'h0000_0000_0000, 52'h1_2345_6789_A000, 12'h0AA);
                queue_word(KIND_MAP,   4'd0,  48'h0000_0000_1FFF, 52'h0_0000_0000_1FFF, 12'h100);
                queue_word(KIND_MAP,   4'd0,  48'h8000_0000_0000, 52'h8_0000_0000_0000, 12'h002);
                queue_word(KIND_MAP,   4'd0,  48'h4000_0000_0000, 52'h4_0000_0000_0000, 12'h004);
                queue_word(KIND_MAP,   4'd0,  48'h2000_0000_0000, 52'h2_0000_0000_0000, 12'h008);
                queue_word(KIND_MAP,   4'd0,  48'h0000_4000_0000, 52'h0_0000_4000_0000, 12'h010);
                queue_word(KIND_MAP,   4'd0,  48'h0000_0020_0000, 52'h0_0000_0020_0000, 12'h020);
                queue_word(KIND_UNMAP, 4'd15, 48'hFFFF_FFFF_F000, 52'h0, 12'h000);
                queue_word(KIND_MAP,   4'd15, 48'h0000_0000_0FFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
            end

            for (n = 0; n < phase_words[p]; n++) begin
                item.kind       = 1'($urandom_range(1));
                item.phys_addr  = 52'({$urandom(), $urandom()});
                item.page_flags = 12'($urandom());
                if ($urandom_range(99) < 75) begin
                    item.virt_addr  = {known_prefix[$urandom_range(known_prefix.size() - 1)],
                                       21'($urandom())};
                    item.root_table = ($urandom_range(99) < 70) ? 4'd0 : 4'($urandom_range(15));
                end else begin
                    item.virt_addr  = 48'({$urandom(), $urandom()});
                    item.root_table = 4'($urandom_range(15));
                end
                pending_requests.push_back(item);
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ptmu_pkg.sv
hw/rtl/ptmu_ram.sv
hw/rtl/ptmu_walk.sv
hw/rtl/page_table_map_unmap_unit.sv
tb/testbench.sv
